/* rtl/assert_macros.svh */
// Assertion macros for the RTL modules of the BMP writer; the back end uses them.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
// Condition that must hold at every clock edge outside reset.
`define RBW_ASSERT_ALWAYS(lbl, clk, rst, cond, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);
// Consequence that must hold in the same cycle as its antecedent.
`define RBW_ASSERT_IMPLY(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
`else
`define RBW_ASSERT_ALWAYS(lbl, clk, rst, cond, msg)
`define RBW_ASSERT_IMPLY(lbl, clk, rst, ante, cons, msg)
`endif
`endif

/* rtl/rbw_pkg.sv */
// Types, constants and the header byte function of the RGB565 to BMP writer.
`default_nettype none
package rbw_pkg;

   localparam int CNT_W      = 13;
   localparam int ADDR_W     = 26;
   localparam int ROWB_W     = 15;
   localparam int IMG_W      = 28;
   localparam int SETTLE_W   = 3;
   localparam int HDR_IDX_W  = 6;

   localparam logic [SETTLE_W-1:0]  SETTLE_CYCLES = 3'd4;
   localparam logic [HDR_IDX_W-1:0] HDR_LAST      = 6'd53;

   localparam logic [CNT_W-1:0] WIDTH_RESET  = 13'd320;
   localparam logic [CNT_W-1:0] HEIGHT_RESET = 13'd240;

   localparam logic [7:0]  MAGIC_B     = 8'h42;
   localparam logic [7:0]  MAGIC_M     = 8'h4D;
   localparam logic [31:0] HDR_BYTES   = 32'd54;
   localparam logic [31:0] INFO_BYTES  = 32'd40;
   localparam logic [31:0] PLANES_BPP  = 32'h0018_0001;
   localparam logic [31:0] PIX_PER_M   = 32'h0000_130B;

   // Register indexes of the configuration port.
   typedef enum logic [0:0] {
      REG_WIDTH  = 1'b0,
      REG_HEIGHT = 1'b1
   } reg_index_type;

   typedef struct packed {
      logic [CNT_W-1:0]  eff_w;
      logic [CNT_W-1:0]  eff_h;
      logic [ROWB_W-1:0] row_bytes;
      logic [1:0]        pad;
      logic [ADDR_W-1:0] bottom;
      logic [31:0]       img;
      logic [31:0]       fsize;
      logic              busy;
   } cfg_type;

   typedef struct packed {
      logic              hdr;
      logic [ADDR_W-1:0] addr;
      logic [7:0]        blue;
      logic [7:0]        green;
      logic [7:0]        red;
      logic [1:0]        pad;
      logic              frame_end;
   } cmd_type;

   typedef enum logic [1:0] {
      PH_START,
      PH_HDR,
      PH_PIX,
      PH_PAD
   } phase_type;

   // Byte idx of the 54-byte file header; multi-byte fields are little-endian.
   function automatic logic [7:0] hdr_byte(input logic [HDR_IDX_W-1:0] idx,
                                           input logic [31:0] fsize,
                                           input logic [31:0] img,
                                           input logic [31:0] width,
                                           input logic [31:0] height);
      logic [HDR_IDX_W-1:0] rel;
      logic [31:0]          field;
      logic [7:0]           res;
      rel   = idx - 6'd2;
      field = '0;
      res   = '0;
      priority if (idx == 6'd0) begin
         res = MAGIC_B;
      end else if (idx == 6'd1) begin
         res = MAGIC_M;
      end else begin
         unique case (rel[5:2])
            4'd0:    field = fsize;
            4'd2:    field = HDR_BYTES;
            4'd3:    field = INFO_BYTES;
            4'd4:    field = width;
            4'd5:    field = height;
            4'd6:    field = PLANES_BPP;
            4'd8:    field = img;
            4'd9:    field = PIX_PER_M;
            4'd10:   field = PIX_PER_M;
            default: field = '0;
         endcase
         res = 8'(field >> {rel[1:0], 3'b000});
      end
      return res;
   endfunction

endpackage
`default_nettype wire

/* rtl/rbw_cfg.sv */
// Configuration registers and the derived frame geometry of the BMP writer.
`default_nettype none
module rbw_cfg #(
   parameter int MAX_WIDTH  = 4096,
   parameter int MAX_HEIGHT = 4096
) (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     csr_valid,
   output logic                          csr_ready,
   input  wire logic [0:0]               csr_index,
   input  wire logic [rbw_pkg::CNT_W-1:0] csr_wdata,
   output rbw_pkg::cfg_type              cfg
);
   import rbw_pkg::*;

   logic [CNT_W-1:0]    width_ff, width_in;
   logic [CNT_W-1:0]    height_ff, height_in;
   logic [SETTLE_W-1:0] settle_ff, settle_in;
   logic [CNT_W-1:0]    eff_w_ff, eff_w_in;
   logic [CNT_W-1:0]    eff_h_ff, eff_h_in;
   logic [ROWB_W-1:0]   row_bytes_ff, row_bytes_in;
   logic [1:0]          pad_ff, pad_in;
   logic [IMG_W-1:0]    img_ff, img_in;
   logic [31:0]         fsize_ff, fsize_in;
   logic [ADDR_W-1:0]   bottom_ff, bottom_in;
   logic [ROWB_W-1:0]   w3;
   logic                wr;

   assign csr_ready = 1'b1;
   assign wr        = csr_valid & csr_ready;

   always_comb begin
      width_in  = width_ff;
      height_in = height_ff;
      if (wr) begin
         unique case (reg_index_type'(csr_index))
            REG_WIDTH:  width_in  = csr_wdata;
            REG_HEIGHT: height_in = csr_wdata;
         endcase
      end
   end

   // Any write restarts the frame; requests wait until the geometry has settled.
   always_comb begin
      settle_in = settle_ff;
      if (wr) begin
         settle_in = SETTLE_CYCLES;
      end else if (settle_ff != '0) begin
         settle_in = settle_ff - 1'b1;
      end
   end

   always_comb begin
      eff_w_in = width_ff;
      if (width_ff == '0) begin
         eff_w_in = CNT_W'(1);
      end else if (32'(width_ff) > MAX_WIDTH) begin
         eff_w_in = CNT_W'(MAX_WIDTH);
      end
      eff_h_in = height_ff;
      if (height_ff == '0) begin
         eff_h_in = CNT_W'(1);
      end else if (32'(height_ff) > MAX_HEIGHT) begin
         eff_h_in = CNT_W'(MAX_HEIGHT);
      end
   end

   assign w3           = ROWB_W'({eff_w_ff, 1'b0}) + ROWB_W'(eff_w_ff);
   assign row_bytes_in = (w3 + ROWB_W'(3)) & ~ROWB_W'(3);
   assign pad_in       = 2'(row_bytes_in - w3);
   assign img_in       = IMG_W'(row_bytes_ff) * IMG_W'(eff_h_ff);
   assign fsize_in     = 32'(img_ff) + HDR_BYTES;
   assign bottom_in    = ADDR_W'(fsize_in) - ADDR_W'(row_bytes_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= WIDTH_RESET;
         height_ff <= HEIGHT_RESET;
         settle_ff <= SETTLE_CYCLES;
      end else begin
         width_ff  <= width_in;
         height_ff <= height_in;
         settle_ff <= settle_in;
      end
   end

   always_ff @(posedge clock) begin
      eff_w_ff     <= eff_w_in;
      eff_h_ff     <= eff_h_in;
      row_bytes_ff <= row_bytes_in;
      pad_ff       <= pad_in;
      img_ff       <= img_in;
      fsize_ff     <= fsize_in;
      bottom_ff    <= bottom_in;
   end

   always_comb begin
      cfg.eff_w     = eff_w_ff;
      cfg.eff_h     = eff_h_ff;
      cfg.row_bytes = row_bytes_ff;
      cfg.pad       = pad_ff;
      cfg.bottom    = bottom_ff;
      cfg.img       = 32'(img_ff);
      cfg.fsize     = fsize_ff;
      cfg.busy      = (settle_ff != '0);
   end

endmodule
`default_nettype wire

/* rtl/rbw_front.sv */
// Front end: accepts pixels, tracks raster position and builds byte commands.
`default_nettype none
module rbw_front (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_push,
   output logic                  req_full,
   input  wire logic [15:0]      req_pixel_rgb565,
   input  wire rbw_pkg::cfg_type cfg,
   input  wire logic             q_ready,
   output logic                  q_push,
   output rbw_pkg::cmd_type      q_cmd
);
   import rbw_pkg::*;

   logic [CNT_W-1:0]  col_ff, col_in;
   logic [CNT_W-1:0]  row_ff, row_in;
   logic [ADDR_W-1:0] row_start_ff, row_start_in;
   logic [ADDR_W-1:0] base;
   logic [CNT_W:0]    col_next;
   logic [CNT_W:0]    row_next;
   logic              first;
   logic              row_end;
   logic              frame_end;
   logic [4:0]        r5;
   logic [5:0]        g6;
   logic [4:0]        b5;

   assign req_full = cfg.busy | ~q_ready;
   assign q_push   = req_push & ~req_full;

   // At the start of a frame the row address comes straight from the geometry.
   assign first     = (col_ff == '0) && (row_ff == '0);
   assign base      = first ? cfg.bottom : row_start_ff;
   assign col_next  = {1'b0, col_ff} + 1'b1;
   assign row_next  = {1'b0, row_ff} + 1'b1;
   assign row_end   = col_next >= {1'b0, cfg.eff_w};
   assign frame_end = row_end && (row_next >= {1'b0, cfg.eff_h});

   assign r5 = req_pixel_rgb565[15:11];
   assign g6 = req_pixel_rgb565[10:5];
   assign b5 = req_pixel_rgb565[4:0];

   always_comb begin
      q_cmd.hdr       = first;
      q_cmd.addr      = base + ADDR_W'({col_ff, 1'b0}) + ADDR_W'(col_ff);
      q_cmd.blue      = {b5, b5[4:2]};
      q_cmd.green     = {g6, g6[5:4]};
      q_cmd.red       = {r5, r5[4:2]};
      q_cmd.pad       = row_end ? cfg.pad : 2'd0;
      q_cmd.frame_end = frame_end;
   end

   always_comb begin
      col_in       = col_ff;
      row_in       = row_ff;
      row_start_in = row_start_ff;
      if (cfg.busy) begin
         col_in = '0;
         row_in = '0;
      end else if (q_push) begin
         priority if (frame_end) begin
            col_in = '0;
            row_in = '0;
         end else if (row_end) begin
            col_in       = '0;
            row_in       = row_next[CNT_W-1:0];
            row_start_in = base - ADDR_W'(cfg.row_bytes);
         end else begin
            col_in       = col_next[CNT_W-1:0];
            row_start_in = base;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff <= '0;
         row_ff <= '0;
      end else begin
         col_ff <= col_in;
         row_ff <= row_in;
      end
   end

   always_ff @(posedge clock) begin
      row_start_ff <= row_start_in;
   end

endmodule
`default_nettype wire

/* rtl/rbw_cmd_queue.sv */
// Two-entry command queue between the front end and the byte sequencer.
`default_nettype none
module rbw_cmd_queue (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             push,
   input  wire rbw_pkg::cmd_type push_cmd,
   output logic                  ready,
   input  wire logic             pop,
   output logic                  valid,
   output rbw_pkg::cmd_type      head
);
   import rbw_pkg::*;

   cmd_type    mem_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;

   assign ready = (count_ff != 2'd2);
   assign valid = (count_ff != 2'd0);
   assign head  = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff ^ push;
      rd_ptr_in = rd_ptr_ff ^ pop;
      count_in  = count_ff + 2'(push) - 2'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_cmd;
      end
   end

endmodule
`default_nettype wire

/* rtl/rbw_back.sv */
// Back end: steps through header, pixel and padding bytes into the result register.
`default_nettype none
`include "assert_macros.svh"
module rbw_back (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire rbw_pkg::cfg_type cfg,
   input  wire logic             q_valid,
   input  wire rbw_pkg::cmd_type head,
   output logic                  q_pop,
   output logic                  rsp_empty,
   input  wire logic             rsp_pop,
   output logic [25:0]           rsp_byte_address,
   output logic [7:0]            rsp_byte_value,
   output logic                  rsp_last_of_run,
   output logic                  rsp_end_of_file,
   output logic [25:0]           rsp_file_size
);
   import rbw_pkg::*;

   phase_type            phase_ff, phase_in;
   logic [HDR_IDX_W-1:0] idx_ff, idx_in;
   logic [ADDR_W-1:0]    addr_ff, addr_in;
   logic                 out_valid_ff, out_valid_in;
   logic [ADDR_W-1:0]    addr_out_ff;
   logic [7:0]           value_out_ff;
   logic                 last_out_ff;
   logic                 eof_out_ff;
   logic [ADDR_W-1:0]    fsize_out_ff;
   phase_type            cur_phase;
   logic [HDR_IDX_W-1:0] cur_idx;
   logic [ADDR_W-1:0]    cur_addr;
   logic [7:0]           byte_val;
   logic                 last;
   logic                 advance;

   // The result register takes a new byte whenever a command is queued and the register is empty or being drained.
   assign advance      = q_valid && (!out_valid_ff || rsp_pop);
   assign q_pop        = advance && last;
   assign out_valid_in = advance || (out_valid_ff && !rsp_pop);

   // Output decode: the start phase stands for the first byte of the head request.
   always_comb begin
      cur_phase = phase_ff;
      cur_idx   = idx_ff;
      cur_addr  = addr_ff;
      if (phase_ff == PH_START) begin
         cur_phase = head.hdr ? PH_HDR : PH_PIX;
         cur_idx   = '0;
         cur_addr  = head.hdr ? '0 : head.addr;
      end
      byte_val = '0;
      last     = 1'b0;
      unique case (cur_phase)
         PH_HDR: begin
            byte_val = hdr_byte(cur_idx, cfg.fsize, cfg.img, 32'(cfg.eff_w), 32'(cfg.eff_h));
         end
         PH_PIX: begin
            unique case (cur_idx[1:0])
               2'd0:    byte_val = head.blue;
               2'd1:    byte_val = head.green;
               default: byte_val = head.red;
            endcase
            last = (cur_idx[1:0] == 2'd2) && (head.pad == 2'd0);
         end
         PH_PAD: begin
            last = (cur_idx[1:0] == head.pad - 2'd1);
         end
         PH_START: begin
            last = 1'b0;
         end
      endcase
   end

   always_comb begin
      phase_in = phase_ff;
      idx_in   = idx_ff;
      addr_in  = addr_ff;
      if (advance) begin
         idx_in  = cur_idx + 1'b1;
         addr_in = cur_addr + 1'b1;
         unique case (cur_phase)
            PH_HDR: begin
               phase_in = PH_HDR;
               if (cur_idx == HDR_LAST) begin
                  phase_in = PH_PIX;
                  idx_in   = '0;
                  addr_in  = head.addr;
               end
            end
            PH_PIX: begin
               phase_in = PH_PIX;
               if (cur_idx[1:0] == 2'd2) begin
                  phase_in = last ? PH_START : PH_PAD;
                  idx_in   = '0;
               end
            end
            PH_PAD: begin
               phase_in = last ? PH_START : PH_PAD;
            end
            PH_START: begin
               phase_in = PH_START;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_START;
         out_valid_ff <= 1'b0;
      end else begin
         phase_ff     <= phase_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff  <= idx_in;
      addr_ff <= addr_in;
      if (advance) begin
         addr_out_ff  <= cur_addr;
         value_out_ff <= byte_val;
         last_out_ff  <= last;
         eof_out_ff   <= last && head.frame_end;
         fsize_out_ff <= cfg.fsize[ADDR_W-1:0];
      end
   end

   assign rsp_empty        = !out_valid_ff;
   assign rsp_byte_address = addr_out_ff;
   assign rsp_byte_value   = value_out_ff;
   assign rsp_last_of_run  = last_out_ff;
   assign rsp_end_of_file  = eof_out_ff;
   assign rsp_file_size    = fsize_out_ff;

   `RBW_ASSERT_IMPLY(a_pop_has_head, clock, reset, q_pop, q_valid, "queue popped while empty")
   `RBW_ASSERT_IMPLY(a_hdr_index, clock, reset, phase_ff == PH_HDR, idx_ff <= HDR_LAST, "header index past end")
   `RBW_ASSERT_IMPLY(a_pad_needed, clock, reset, advance && cur_phase == PH_PAD, head.pad != 2'd0, "padding byte without padding")
   `RBW_ASSERT_IMPLY(a_eof_is_last, clock, reset, out_valid_ff && rsp_end_of_file, rsp_last_of_run, "end of file on a byte that does not end its request")

endmodule
`default_nettype wire

/* rtl/rgb565_to_bmp24_writer_top.sv */
// Top level of the RGB565 to 24-bit BMP byte writer.
`default_nettype none
// Takes RGB565 pixels in raster order (top row first) and produces the addressed
// bytes of a bottom-up 24-bit BMP file, one byte per cycle on the response side
// while commands are queued and bytes are popped. A pixel gives 3 bytes; the last
// pixel of a row adds 0 to 3 padding bytes and the first pixel of a frame adds the
// 54 header bytes. The byte sequencer in the back end fills a single output
// register; a two-entry command queue lets the request side run ahead of it.
// After reset and after every configuration write, full stays high while the
// frame geometry is recomputed, and the next pixel starts a new file.
module rgb565_to_bmp24_writer_top #(
   parameter int MAX_WIDTH  = 4096,
   parameter int MAX_HEIGHT = 4096
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_push,
   output logic             req_full,
   input  wire logic [15:0] req_pixel_rgb565,
   output logic             rsp_empty,
   input  wire logic        rsp_pop,
   output logic [25:0]      rsp_byte_address,
   output logic [7:0]       rsp_byte_value,
   output logic             rsp_last_of_run,
   output logic             rsp_end_of_file,
   output logic [25:0]      rsp_file_size,
   input  wire logic        csr_valid,
   output logic             csr_ready,
   input  wire logic [0:0]  csr_index,
   input  wire logic [12:0] csr_wdata
);
   import rbw_pkg::*;

   cfg_type cfg;
   cmd_type push_cmd;
   cmd_type head;
   logic    q_push;
   logic    q_ready;
   logic    q_valid;
   logic    q_pop;

   rbw_cfg #(
      .MAX_WIDTH  (MAX_WIDTH),
      .MAX_HEIGHT (MAX_HEIGHT)
   ) u_cfg (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   rbw_front u_front (
      .clock            (clock),
      .reset            (reset),
      .req_push         (req_push),
      .req_full         (req_full),
      .req_pixel_rgb565 (req_pixel_rgb565),
      .cfg              (cfg),
      .q_ready          (q_ready),
      .q_push           (q_push),
      .q_cmd            (push_cmd)
   );

   rbw_cmd_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (q_push),
      .push_cmd (push_cmd),
      .ready    (q_ready),
      .pop      (q_pop),
      .valid    (q_valid),
      .head     (head)
   );

   rbw_back u_back (
      .clock            (clock),
      .reset            (reset),
      .cfg              (cfg),
      .q_valid          (q_valid),
      .head             (head),
      .q_pop            (q_pop),
      .rsp_empty        (rsp_empty),
      .rsp_pop          (rsp_pop),
      .rsp_byte_address (rsp_byte_address),
      .rsp_byte_value   (rsp_byte_value),
      .rsp_last_of_run  (rsp_last_of_run),
      .rsp_end_of_file  (rsp_end_of_file),
      .rsp_file_size    (rsp_file_size)
   );

endmodule
`default_nettype wire

/* verif/tb.sv */
// Self-checking testbench for the RGB565 to 24-bit BMP byte writer.
`default_nettype none
module tb;
   import rbw_pkg::*;

   localparam int CYCLE_LIMIT   = 300000;
   localparam int RANDOM_PIXELS = 400;

   // Predicts the addressed file bytes that each pixel request causes.
   class bmp_byte_board;
      localparam int MAX_SIDE = 4096;

      typedef struct packed {
         logic [25:0] addr;
         logic [7:0]  value;
         logic        last;
         logic        eof;
         logic [25:0] fsize;
      } file_byte_type;

      file_byte_type byte_q[$];
      logic [12:0]   width_reg;
      logic [12:0]   height_reg;
      int unsigned   col;
      int unsigned   row;
      logic [25:0]   row_start;
      int unsigned   file_len;
      int            fails;

      task report(string msg);
         if (fails < 100) $display("tb: mismatch at %0t: %s", $time, msg);
         fails++;
      endtask

      function int unsigned clamp_side(logic [12:0] v);
         if (v == 13'd0) return 1;
         if (v > MAX_SIDE) return MAX_SIDE;
         return 32'(v);
      endfunction

      function int unsigned row_bytes();
         return (clamp_side(width_reg) * 3 + 3) & ~32'd3;
      endfunction

      function void restart();
         col = 0;
         row = 0;
         row_start = 26'(54 + (clamp_side(height_reg) - 1) * row_bytes());
      endfunction

      function void reset_state();
         width_reg  = WIDTH_RESET;
         height_reg = HEIGHT_RESET;
         restart();
      endfunction

      function void write_reg(reg_index_type idx, logic [12:0] value);
         case (idx)
            REG_WIDTH:  width_reg = value;
            REG_HEIGHT: height_reg = value;
            default:    ;
         endcase
         restart();
      endfunction

      function int pending();
         return byte_q.size();
      endfunction

      function void put_byte(int unsigned addr, int unsigned value);
         file_byte_type b;
         b.addr  = 26'(addr);
         b.value = 8'(value);
         b.last  = 1'b0;
         b.eof   = 1'b0;
         b.fsize = 26'(file_len);
         byte_q.push_back(b);
      endfunction

      function void put_word(inout int unsigned addr, input int unsigned value, input int len);
         for (int i = 0; i < len; i++) begin
            put_byte(addr, value >> (8 * i));
            addr++;
         end
      endfunction

      function void note_pixel(logic [15:0] px);
         int unsigned   w;
         int unsigned   h;
         int unsigned   rb;
         int unsigned   img;
         int unsigned   a;
         logic [4:0]    r5;
         logic [5:0]    g6;
         logic [4:0]    b5;
         bit            row_end;
         bit            frame_end;
         file_byte_type tail;
         w = clamp_side(width_reg);
         h = clamp_side(height_reg);
         rb = row_bytes();
         img = rb * h;
         file_len = 54 + img;
         {r5, g6, b5} = px;
         // The first pixel of a frame is preceded by the whole file header.
         if (col == 0 && row == 0) begin
            a = 0;
            put_word(a, 32'h4D42, 2);
            put_word(a, file_len, 4);
            put_word(a, 0, 4);
            put_word(a, 54, 4);
            put_word(a, 40, 4);
            put_word(a, w, 4);
            put_word(a, h, 4);
            put_word(a, 1, 2);
            put_word(a, 24, 2);
            put_word(a, 0, 4);
            put_word(a, img, 4);
            put_word(a, 32'h130B, 4);
            put_word(a, 32'h130B, 4);
            put_word(a, 0, 4);
            put_word(a, 0, 4);
         end
         a = row_start + col * 3;
         put_byte(a, {b5, b5[4:2]});
         put_byte(a + 1, {g6, g6[5:4]});
         put_byte(a + 2, {r5, r5[4:2]});
         row_end = (col + 1 >= w);
         frame_end = row_end && (row + 1 >= h);
         if (row_end) begin
            for (int unsigned i = 0; i < rb - w * 3; i++) put_byte(row_start + w * 3 + i, 0);
         end
         tail = byte_q.pop_back();
         tail.last = 1'b1;
         tail.eof = frame_end;
         byte_q.push_back(tail);
         if (frame_end) begin
            restart();
         end else if (row_end) begin
            col = 0;
            row++;
            row_start = row_start - 26'(rb);
         end else begin
            col++;
         end
      endfunction

      task check_byte(logic [25:0] addr, logic [7:0] value, logic last, logic eof,
                      logic [25:0] fsize);
         file_byte_type want;
         if (byte_q.size() == 0) begin
            report($sformatf("unexpected byte %0h at address %0d", value, addr));
            return;
         end
         want = byte_q.pop_front();
         if (addr !== want.addr)
            report($sformatf("address %0d, expected %0d", addr, want.addr));
         if (value !== want.value)
            report($sformatf("value %0h at %0d, expected %0h", value, want.addr, want.value));
         if (last !== want.last)
            report($sformatf("last_of_run %b at %0d, expected %b", last, want.addr, want.last));
         if (eof !== want.eof)
            report($sformatf("end_of_file %b at %0d, expected %b", eof, want.addr, want.eof));
         if (fsize !== want.fsize)
            report($sformatf("file_size %0d, expected %0d", fsize, want.fsize));
      endtask
   endclass

   logic          clock = 1'b0;
   logic          reset = 1'b1;
   logic          req_push = 1'b0;
   logic          req_full;
   logic [15:0]   req_pixel_rgb565 = '0;
   logic          rsp_empty;
   logic          rsp_pop = 1'b0;
   logic [25:0]   rsp_byte_address;
   logic [7:0]    rsp_byte_value;
   logic          rsp_last_of_run;
   logic          rsp_end_of_file;
   logic [25:0]   rsp_file_size;
   logic          csr_valid = 1'b0;
   logic          csr_ready;
   reg_index_type csr_index = REG_WIDTH;
   logic [12:0]   csr_wdata = '0;

   bmp_byte_board board = new();
   bit            calm = 1'b0;
   int            hold_len = 0;
   int unsigned   cycle_count = 0;

   rgb565_to_bmp24_writer_top u_top (
      .clock            (clock),
      .reset            (reset),
      .req_push         (req_push),
      .req_full         (req_full),
      .req_pixel_rgb565 (req_pixel_rgb565),
      .rsp_empty        (rsp_empty),
      .rsp_pop          (rsp_pop),
      .rsp_byte_address (rsp_byte_address),
      .rsp_byte_value   (rsp_byte_value),
      .rsp_last_of_run  (rsp_last_of_run),
      .rsp_end_of_file  (rsp_end_of_file),
      .rsp_file_size    (rsp_file_size),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("tb: errors");
         $finish;
      end
   end

   task automatic push_pixel(input logic [15:0] px);
      while (!calm && $urandom_range(99) < 6) begin
         req_push <= 1'b0;
         @(posedge clock);
      end
      req_push <= 1'b1;
      req_pixel_rgb565 <= px;
      @(posedge clock);
      while (req_full) @(posedge clock);
      board.note_pixel(px);
   endtask

   // Stops the requests and waits until every predicted byte has been taken.
   task automatic drain();
      req_push <= 1'b0;
      while (board.pending() != 0) @(posedge clock);
   endtask

   task automatic write_csr(input reg_index_type idx, input logic [12:0] value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      board.write_reg(idx, value);
   endtask

   task automatic set_geometry(input logic [12:0] w, input logic [12:0] h, input bit do_w,
                               input bit do_h);
      drain();
      if (do_w) write_csr(REG_WIDTH, w);
      if (do_h) write_csr(REG_HEIGHT, h);
      csr_valid <= 1'b0;
   endtask

   task automatic push_random(input int count);
      for (int i = 0; i < count; i++) begin
         if ($urandom_range(9) == 0) push_pixel($urandom_range(1) ? 16'hFFFF : 16'h0000);
         else push_pixel(16'($urandom));
      end
   endtask

   // Result side: random pops, plus one long hold-off on request.
   initial begin
      int stall;
      forever begin
         if (hold_len != 0) begin
            stall = hold_len;
            hold_len = 0;
            rsp_pop <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_pop <= calm || $urandom_range(99) >= 6;
         @(posedge clock);
         if (rsp_pop && !rsp_empty && !reset)
            board.check_byte(rsp_byte_address, rsp_byte_value, rsp_last_of_run,
                             rsp_end_of_file, rsp_file_size);
      end
   end

   initial begin
      int          sent;
      int          phase;
      int          pick;
      int          count;
      int          which;
      logic [12:0] w;
      logic [12:0] h;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      board.reset_state();

      // Reset geometry, then sizes that exercise every padding amount.
      push_pixel(16'h0000);
      push_pixel(16'hFFFF);
      set_geometry(13'd0, 13'd0, 1'b1, 1'b1);
      push_pixel(16'hF800);
      push_pixel(16'h07E0);
      set_geometry(13'd2, 13'd2, 1'b1, 1'b1);
      // Five pixels into 2x2 frames leave the next write in the middle of a frame.
      push_pixel(16'h001F);
      push_pixel(16'h8410);
      push_pixel(16'h7BEF);
      push_pixel(16'h0821);
      push_pixel(16'hFFDF);
      set_geometry(13'd3, 13'd1, 1'b1, 1'b1);
      push_pixel(16'h5555);
      push_pixel(16'hAAAA);
      push_pixel(16'h1234);
      set_geometry(13'd4, 13'd2, 1'b1, 1'b1);
      push_pixel(16'hF81F);
      push_pixel(16'h07FF);
      push_pixel(16'hFFE0);
      push_pixel(16'h0001);
      set_geometry(13'd8191, 13'd8191, 1'b1, 1'b1);
      push_pixel(16'h8000);
      push_pixel(16'h0020);
      set_geometry(13'd4096, 13'd4096, 1'b1, 1'b1);
      push_pixel(16'hFFFF);
      push_pixel(16'h0000);
      set_geometry(13'd4097, 13'd4097, 1'b1, 1'b1);
      push_pixel(16'hC618);

      sent = 0;
      phase = 0;
      while (sent < RANDOM_PIXELS) begin
         pick = $urandom_range(99);
         which = $urandom_range(9);
         count = $urandom_range(1, 40);
         if (pick < 70) begin
            w = 13'($urandom_range(1, 9));
            h = 13'($urandom_range(1, 4));
         end else if (pick < 85) begin
            w = 13'($urandom_range(1, 64));
            h = 13'($urandom_range(1, 8));
         end else begin
            w = 13'($urandom);
            h = 13'($urandom);
            count = $urandom_range(1, 6);
         end
         if (phase == 2) begin
            // One-pixel frames with the result side held off fill the block up.
            w = 13'd1;
            h = 13'd1;
            which = 9;
            count = 30;
         end
         set_geometry(w, h, which != 1, which != 0);
         if (phase == 2) hold_len = 300;
         calm = (phase == 4);
         if (phase == 4) count = 60;
         push_random(count);
         calm = 1'b0;
         sent += count;
         phase++;
      end

      drain();
      repeat (20) @(posedge clock);
      if (board.fails == 0) begin
         $display("tb: clean");
      end else begin
         $display("tb: errors");
      end
      $finish;
   end

endmodule
`default_nettype wire
